// ===== rtl/etc2_rgba_block_decoder_core_macros.svh =====
// Assertion macros shared by the ETC2 block decoder modules
`ifndef ETC2_RGBA_BLOCK_DECODER_CORE_MACROS_SVH
`define ETC2_RGBA_BLOCK_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check that antecedent implies consequent on the same edge
`define ETC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Check that antecedent implies consequent on the next edge
`define ETC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ETC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ETC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/etc2_pkg.sv =====
// Package: payload types, mode codes and constant tables of the ETC2 block decoder
`default_nettype none
package etc2_pkg;
	typedef struct packed {
		logic [63:0] color_word;
		logic [63:0] alpha_word;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [1:0] pixel_x;
		logic [1:0] pixel_y;
		logic       last_pixel;
	} out_word_t;

	typedef enum logic [2:0] {
		MODE_INDIV  = 3'd0,
		MODE_DIFF   = 3'd1,
		MODE_T      = 3'd2,
		MODE_H      = 3'd3,
		MODE_PLANAR = 3'd4
	} mode_t;

	// Classified block handed from front to back
	typedef struct packed {
		mode_t       mode;
		logic [63:0] color_word;
		logic [63:0] alpha_word;
		logic        has_alpha;
	} blk_t;

	localparam int QDEPTH = 2;

	function automatic logic [7:0] etc1_mod(input logic [2:0] tw, input logic [1:0] idx);
		logic [7:0] m;
		case (tw)
			3'd0: m = 8'd2;
			3'd1: m = 8'd5;
			3'd2: m = 8'd9;
			3'd3: m = 8'd13;
			3'd4: m = 8'd18;
			3'd5: m = 8'd24;
			3'd6: m = 8'd33;
			default: m = 8'd47;
		endcase
		if (idx[0]) begin
			case (tw)
				3'd0: m = 8'd8;
				3'd1: m = 8'd17;
				3'd2: m = 8'd29;
				3'd3: m = 8'd42;
				3'd4: m = 8'd60;
				3'd5: m = 8'd80;
				3'd6: m = 8'd106;
				default: m = 8'd150;
			endcase
		end
		return m;
	endfunction

	// Magnitude of the EAC modifier; sign comes from index bit 2 (clear = negative)
	function automatic logic [3:0] eac_mag(input logic [3:0] tab, input logic [2:0] idx);
		logic [15:0] r;
		case (tab)
			4'd0:  r = {4'd3, 4'd6, 4'd9, 4'd15};
			4'd1:  r = {4'd3, 4'd7, 4'd10, 4'd13};
			4'd2:  r = {4'd2, 4'd5, 4'd8, 4'd13};
			4'd3:  r = {4'd2, 4'd4, 4'd6, 4'd13};
			4'd4:  r = {4'd3, 4'd6, 4'd8, 4'd12};
			4'd5:  r = {4'd3, 4'd7, 4'd9, 4'd11};
			4'd6:  r = {4'd4, 4'd7, 4'd8, 4'd11};
			4'd7:  r = {4'd3, 4'd5, 4'd8, 4'd11};
			4'd8:  r = {4'd2, 4'd6, 4'd8, 4'd10};
			4'd9:  r = {4'd2, 4'd5, 4'd8, 4'd10};
			4'd10: r = {4'd2, 4'd4, 4'd8, 4'd10};
			4'd11: r = {4'd2, 4'd5, 4'd7, 4'd10};
			4'd12: r = {4'd3, 4'd4, 4'd7, 4'd10};
			4'd13: r = {4'd1, 4'd2, 4'd3, 4'd10};
			4'd14: r = {4'd4, 4'd6, 4'd8, 4'd9};
			default: r = {4'd3, 4'd5, 4'd7, 4'd9};
		endcase
		// positive entries are the negative ones minus one
		case (idx[1:0])
			2'd0: eac_mag = r[15:12];
			2'd1: eac_mag = r[11:8];
			2'd2: eac_mag = r[7:4];
			default: eac_mag = r[3:0];
		endcase
		if (idx[2]) eac_mag = eac_mag - 4'd1;
	endfunction

	function automatic logic [6:0] th_dist(input logic [2:0] i);
		case (i)
			3'd0: th_dist = 7'd3;
			3'd1: th_dist = 7'd6;
			3'd2: th_dist = 7'd11;
			3'd3: th_dist = 7'd16;
			3'd4: th_dist = 7'd23;
			3'd5: th_dist = 7'd32;
			3'd6: th_dist = 7'd47;
			default: th_dist = 7'd64;
		endcase
	endfunction

	function automatic logic [7:0] sat8(input logic signed [13:0] v);
		if (v < 0) sat8 = 8'd0;
		else if (v > 14'sd255) sat8 = 8'd255;
		else sat8 = v[7:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/etc2_front.sv =====
// Front end: accept blocks, classify the colour mode, queue them for the back end
`default_nettype none
module etc2_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire etc2_pkg::in_word_t in_word,
	input  wire logic              has_alpha,
	output logic                   blk_valid,
	input  wire logic              blk_take,
	output etc2_pkg::blk_t         blk
);
	etc2_pkg::blk_t     q_mem_q [etc2_pkg::QDEPTH];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         cnt_q;
	etc2_pkg::mode_t    mode;
	logic signed [5:0]  r2, g2, b2;
	logic [63:0]        w;
	logic               do_push, do_pop;

	assign w = in_word.color_word;
	assign r2 = $signed({1'b0, w[63:59]}) + $signed({{3{w[58]}}, w[58:56]});
	assign g2 = $signed({1'b0, w[55:51]}) + $signed({{3{w[50]}}, w[50:48]});
	assign b2 = $signed({1'b0, w[47:43]}) + $signed({{3{w[42]}}, w[42:40]});

	// Classify the mode from the diff bit and the overflow of each channel
	always_comb begin
		if (!w[33]) mode = etc2_pkg::MODE_INDIV;
		else if (r2 < 0 || r2 > 6'sd31) mode = etc2_pkg::MODE_T;
		else if (g2 < 0 || g2 > 6'sd31) mode = etc2_pkg::MODE_H;
		else if (b2 < 0 || b2 > 6'sd31) mode = etc2_pkg::MODE_PLANAR;
		else mode = etc2_pkg::MODE_DIFF;
	end

	assign full = (cnt_q == 2'(etc2_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop = blk_take && blk_valid;
	assign blk_valid = (cnt_q != 2'd0);
	assign blk = q_mem_q[rd_ptr_q];

	// Write classified words into the queue
	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= '{mode: mode, color_word: in_word.color_word,
				alpha_word: in_word.alpha_word, has_alpha: has_alpha};
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	`include "etc2_rgba_block_decoder_core_macros.svh"
	`ETC_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(etc2_pkg::QDEPTH))
	`ETC_ASSERT_NEXT(a_full_push, clk, arst_n, full && !do_pop, full)
	`ETC_ASSERT_IMP(a_ptrs, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2,
		wr_ptr_q == rd_ptr_q)
endmodule
`default_nettype wire

// ===== rtl/etc2_back.sv =====
// Back end: walk the 16 pixels of a queued block and decode colour and alpha
`default_nettype none
module etc2_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            blk_valid,
	output logic                 blk_take,
	input  wire etc2_pkg::blk_t  blk,
	output logic                 empty,
	input  wire logic            pop,
	output etc2_pkg::out_word_t  out_word
);
	// Stage 1 registers: per-pixel operands
	logic               v_s1;
	etc2_pkg::mode_t    mode_s1;
	logic [63:0]        cw_s1;
	logic [1:0]         x_s1, y_s1, idx_s1;
	logic               last_s1, ha_s1;
	logic [7:0]         abase_s1;
	logic [3:0]         amult_s1;
	logic               aneg_s1;
	logic [3:0]         amag_s1;
	// Output register
	logic               v_s2;
	etc2_pkg::out_word_t out_s2;
	logic [3:0]         k_q;
	logic               adv, s2_ready;
	logic [3:0]         pos;
	logic [5:0]         apos;
	logic [2:0]         aidx;
	logic [63:0]        aw;

	assign s2_ready = !v_s2 || pop;
	assign adv = !v_s1 || s2_ready;
	assign blk_take = blk_valid && adv && (k_q == 4'd15);
	assign pos = {k_q[1:0], k_q[3:2]};
	assign aw = blk.alpha_word;
	assign apos = 6'd45 - 6'(pos) * 6'd3;
	assign aidx = aw[apos +: 3];

	// Advance the pixel counter and load stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 4'd0;
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= blk_valid;
			if (blk_valid) k_q <= k_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= blk.mode;
			cw_s1 <= blk.color_word;
			x_s1 <= k_q[1:0];
			y_s1 <= k_q[3:2];
			idx_s1 <= {blk.color_word[{2'b01, pos}], blk.color_word[{2'b00, pos}]};
			last_s1 <= (k_q == 4'd15);
			ha_s1 <= blk.has_alpha;
			abase_s1 <= aw[63:56];
			amult_s1 <= aw[55:52];
			aneg_s1 <= !aidx[2];
			amag_s1 <= etc2_pkg::eac_mag(aw[51:48], aidx);
		end
	end

	// Stage 2 colour and alpha decode
	logic [7:0]  red, green, blue, alpha;
	logic [7:0]  b0 [3], b1 [3], c1 [3], c2 [3];
	logic [7:0]  ro, go, bo, rh, gh, bh, rv, gv, bv;
	logic [6:0]  d;
	logic        sub, ord;
	logic [7:0]  m;
	logic [7:0]  amul;
	logic [4:0]  r2, g2, b2;

	function automatic logic [7:0] ext4(input logic [3:0] v);
		return {v, v};
	endfunction
	function automatic logic [7:0] ext5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction
	function automatic logic [7:0] ext6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction
	function automatic logic [7:0] ext7(input logic [6:0] v);
		return {v, v[6]};
	endfunction
	function automatic logic [7:0] plane(input logic [7:0] o, input logic [7:0] h,
			input logic [7:0] v, input logic [1:0] x, input logic [1:0] y);
		logic signed [13:0] s;
		s = $signed({12'd0, x}) * ($signed({6'd0, h}) - $signed({6'd0, o}))
			+ $signed({12'd0, y}) * ($signed({6'd0, v}) - $signed({6'd0, o}))
			+ $signed({4'd0, o, 2'd0}) + 14'sd2;
		return etc2_pkg::sat8(s >>> 2);
	endfunction
	function automatic logic [7:0] addm(input logic [7:0] b, input logic [7:0] mm,
			input logic neg);
		logic signed [13:0] s;
		s = neg ? $signed({6'd0, b}) - $signed({6'd0, mm})
			: $signed({6'd0, b}) + $signed({6'd0, mm});
		return etc2_pkg::sat8(s);
	endfunction

	always_comb begin
		r2 = cw_s1[63:59] + {{2{cw_s1[58]}}, cw_s1[58:56]};
		g2 = cw_s1[55:51] + {{2{cw_s1[50]}}, cw_s1[50:48]};
		b2 = cw_s1[47:43] + {{2{cw_s1[42]}}, cw_s1[42:40]};
		if (mode_s1 == etc2_pkg::MODE_INDIV) begin
			b0[0] = ext4(cw_s1[63:60]); b0[1] = ext4(cw_s1[55:52]);
			b0[2] = ext4(cw_s1[47:44]);
			b1[0] = ext4(cw_s1[59:56]); b1[1] = ext4(cw_s1[51:48]);
			b1[2] = ext4(cw_s1[43:40]);
		end else begin
			b0[0] = ext5(cw_s1[63:59]); b0[1] = ext5(cw_s1[55:51]);
			b0[2] = ext5(cw_s1[47:43]);
			b1[0] = ext5(r2); b1[1] = ext5(g2); b1[2] = ext5(b2);
		end
		sub = cw_s1[32] ? y_s1[1] : x_s1[1];
		m = etc2_pkg::etc1_mod(sub ? cw_s1[36:34] : cw_s1[39:37], idx_s1);
		if (mode_s1 == etc2_pkg::MODE_T) begin
			c1[0] = ext4({cw_s1[60:59], cw_s1[57:56]});
			c1[1] = ext4(cw_s1[55:52]); c1[2] = ext4(cw_s1[51:48]);
			c2[0] = ext4(cw_s1[47:44]); c2[1] = ext4(cw_s1[43:40]);
			c2[2] = ext4(cw_s1[39:36]);
			ord = 1'b0;
			d = etc2_pkg::th_dist({cw_s1[35:34], cw_s1[32]});
		end else begin
			c1[0] = ext4(cw_s1[62:59]);
			c1[1] = ext4({cw_s1[58:56], cw_s1[52]});
			c1[2] = ext4({cw_s1[51], cw_s1[49:47]});
			c2[0] = ext4(cw_s1[46:43]); c2[1] = ext4(cw_s1[42:39]);
			c2[2] = ext4(cw_s1[38:35]);
			ord = {c1[0][3:0], c1[1][3:0], c1[2][3:0]} >=
				{c2[0][3:0], c2[1][3:0], c2[2][3:0]};
			d = etc2_pkg::th_dist({cw_s1[34], cw_s1[32], ord});
		end
		ro = ext6(cw_s1[62:57]);
		go = ext7({cw_s1[56], cw_s1[54:49]});
		bo = ext6({cw_s1[48], cw_s1[44:43], cw_s1[41:39]});
		rh = ext6({cw_s1[38:34], cw_s1[32]});
		gh = ext7(cw_s1[31:25]);
		bh = ext6(cw_s1[24:19]);
		rv = ext6(cw_s1[18:13]);
		gv = ext7(cw_s1[12:6]);
		bv = ext6(cw_s1[5:0]);
		case (mode_s1)
			etc2_pkg::MODE_T: begin
				case (idx_s1)
					2'd0: begin red = c1[0]; green = c1[1]; blue = c1[2]; end
					2'd1: begin
						red = addm(c2[0], {1'b0, d}, 1'b0);
						green = addm(c2[1], {1'b0, d}, 1'b0);
						blue = addm(c2[2], {1'b0, d}, 1'b0);
					end
					2'd2: begin red = c2[0]; green = c2[1]; blue = c2[2]; end
					default: begin
						red = addm(c2[0], {1'b0, d}, 1'b1);
						green = addm(c2[1], {1'b0, d}, 1'b1);
						blue = addm(c2[2], {1'b0, d}, 1'b1);
					end
				endcase
			end
			etc2_pkg::MODE_H: begin
				red = addm(idx_s1[1] ? c2[0] : c1[0], {1'b0, d}, idx_s1[0]);
				green = addm(idx_s1[1] ? c2[1] : c1[1], {1'b0, d}, idx_s1[0]);
				blue = addm(idx_s1[1] ? c2[2] : c1[2], {1'b0, d}, idx_s1[0]);
			end
			etc2_pkg::MODE_PLANAR: begin
				red = plane(ro, rh, rv, x_s1, y_s1);
				green = plane(go, gh, gv, x_s1, y_s1);
				blue = plane(bo, bh, bv, x_s1, y_s1);
			end
			default: begin
				red = addm(sub ? b1[0] : b0[0], m, idx_s1[1]);
				green = addm(sub ? b1[1] : b0[1], m, idx_s1[1]);
				blue = addm(sub ? b1[2] : b0[2], m, idx_s1[1]);
			end
		endcase
		amul = {4'd0, amag_s1} * {4'd0, amult_s1};
		alpha = ha_s1 ? addm(abase_s1, amul, aneg_s1) : 8'd255;
	end

	// Hold the result until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (s2_ready) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			out_s2 <= '{red: red, green: green, blue: blue, alpha: alpha,
				pixel_x: x_s1, pixel_y: y_s1, last_pixel: last_s1};
		end
	end

	assign empty = !v_s2;
	assign out_word = out_s2;

	`include "etc2_rgba_block_decoder_core_macros.svh"
	`ETC_ASSERT_IMP(a_take_last, clk, arst_n, blk_take, k_q == 4'd15)
	`ETC_ASSERT_NEXT(a_hold, clk, arst_n, v_s2 && !pop, v_s2 && $stable(out_s2))
	`ETC_ASSERT_IMP(a_last_xy, clk, arst_n, v_s2 && out_s2.last_pixel,
		out_s2.pixel_x == 2'd3 && out_s2.pixel_y == 2'd3)
endmodule
`default_nettype wire

// ===== rtl/etc2_rgba_block_decoder_core.sv =====
// Top level of the ETC2 RGB8/RGBA8 4x4 block decoder
//  channel  | handshake          | data
//  input    | push / full        | in_word  (color_word, alpha_word)
//  result   | pop / empty        | out_word (rgba, pixel_x, pixel_y, last_pixel)
//  config   | cfg_valid/cfg_ready| cfg_data (format_has_alpha)
// Each block gives 16 pixels, one a cycle unless a stalled pop holds them; the
// back end's pixel counter takes a block from the queue with its last pixel.
// Pixels pass through the stage 1 registers and the output register.
// A two-entry block queue decouples the front from the back end.
// Reset clears the queue, the pixel counter and the format register.
// A stalled pop holds the output word and backs up into the queue.
`default_nettype none
module etc2_rgba_block_decoder_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire etc2_pkg::in_word_t  in_word,
	output logic                     empty,
	input  wire logic                pop,
	output etc2_pkg::out_word_t      out_word,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_data
);
	logic           has_alpha_q;
	logic           blk_valid, blk_take;
	etc2_pkg::blk_t blk;

	assign cfg_ready = 1'b1;

	// Hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) has_alpha_q <= 1'b0;
		else if (cfg_valid) has_alpha_q <= cfg_data;
	end

	etc2_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.has_alpha(has_alpha_q), .blk_valid(blk_valid), .blk_take(blk_take), .blk(blk)
	);

	etc2_back u_back (
		.clk(clk), .arst_n(arst_n), .blk_valid(blk_valid), .blk_take(blk_take),
		.blk(blk), .empty(empty), .pop(pop), .out_word(out_word)
	);
endmodule
`default_nettype wire

// ===== verif/tb_etc2_rgba_block_decoder_core.sv =====
// Testbench for the ETC2 RGB8/RGBA8 block decoder: directed and random blocks, checked per pixel
`default_nettype none
module tb_etc2_rgba_block_decoder_core;
	// Decoding tables
	localparam int TH_DIST[8] = '{3, 6, 11, 16, 23, 32, 47, 64};
	localparam int ETC_MOD[8][4] = '{
		'{2, 8, -2, -8}, '{5, 17, -5, -17}, '{9, 29, -9, -29}, '{13, 42, -13, -42},
		'{18, 60, -18, -60}, '{24, 80, -24, -80}, '{33, 106, -33, -106},
		'{47, 150, -47, -150}};
	localparam int ALPHA_MOD[16][8] = '{
		'{-3, -6, -9, -15, 2, 5, 8, 14}, '{-3, -7, -10, -13, 2, 6, 9, 12},
		'{-2, -5, -8, -13, 1, 4, 7, 12}, '{-2, -4, -6, -13, 1, 3, 5, 12},
		'{-3, -6, -8, -12, 2, 5, 7, 11}, '{-3, -7, -9, -11, 2, 6, 8, 10},
		'{-4, -7, -8, -11, 3, 6, 7, 10}, '{-3, -5, -8, -11, 2, 4, 7, 10},
		'{-2, -6, -8, -10, 1, 5, 7, 9}, '{-2, -5, -8, -10, 1, 4, 7, 9},
		'{-2, -4, -8, -10, 1, 3, 7, 9}, '{-2, -5, -7, -10, 1, 4, 6, 9},
		'{-3, -4, -7, -10, 2, 3, 6, 9}, '{-1, -2, -3, -10, 0, 1, 2, 9},
		'{-4, -6, -8, -9, 3, 5, 7, 8}, '{-3, -5, -7, -9, 2, 4, 6, 8}};

	function automatic int clamp8(input int v);
		return v < 0 ? 0 : (v > 255 ? 255 : v);
	endfunction

	function automatic int bits(input logic [63:0] w, input int lo, input int n);
		return int'((w >> lo) & ((64'd1 << n) - 1));
	endfunction

	function automatic int x4(input int v); return v * 17; endfunction
	function automatic int x5(input int v); return (v << 3) | (v >> 2); endfunction
	function automatic int x6(input int v); return (v << 2) | (v >> 4); endfunction
	function automatic int x7(input int v); return (v << 1) | (v >> 6); endfunction
	function automatic int sgn3(input int v); return (v & 4) ? v - 8 : v; endfunction

	function automatic int plane_val(input int o, input int h, input int v,
			input int x, input int y);
		int s;
		s = x * (h - o) + y * (v - o) + 4 * o + 2 + 4096;
		return clamp8((s >>> 2) - 1024);
	endfunction

	// Decode one pixel color of an ETC2 block
	function automatic void decode_rgb(input logic [63:0] w, input int x, input int y,
			output int c[3]);
		int pos, idx, r5, g5, b5, r2, g2, b2, d, ord, sub, tw, m, p;
		int b0[3], b1[3], c1[3], c2[3];
		pos = x * 4 + y;
		idx = (bits(w, pos + 16, 1) << 1) | bits(w, pos, 1);
		if (bits(w, 33, 1) == 0) begin
			b0 = '{x4(bits(w, 60, 4)), x4(bits(w, 52, 4)), x4(bits(w, 44, 4))};
			b1 = '{x4(bits(w, 56, 4)), x4(bits(w, 48, 4)), x4(bits(w, 40, 4))};
		end else begin
			r5 = bits(w, 59, 5); g5 = bits(w, 51, 5); b5 = bits(w, 43, 5);
			r2 = r5 + sgn3(bits(w, 56, 3));
			g2 = g5 + sgn3(bits(w, 48, 3));
			b2 = b5 + sgn3(bits(w, 40, 3));
			if (r2 < 0 || r2 > 31) begin
				c1 = '{x4((bits(w, 59, 2) << 2) | bits(w, 56, 2)), x4(bits(w, 52, 4)),
					x4(bits(w, 48, 4))};
				c2 = '{x4(bits(w, 44, 4)), x4(bits(w, 40, 4)), x4(bits(w, 36, 4))};
				d = TH_DIST[(bits(w, 34, 2) << 1) | bits(w, 32, 1)];
				for (int i = 0; i < 3; i++) begin
					case (idx)
						0: c[i] = c1[i];
						1: c[i] = clamp8(c2[i] + d);
						2: c[i] = c2[i];
						default: c[i] = clamp8(c2[i] - d);
					endcase
				end
				return;
			end
			if (g2 < 0 || g2 > 31) begin
				c1 = '{bits(w, 59, 4), (bits(w, 56, 3) << 1) | bits(w, 52, 1),
					(bits(w, 51, 1) << 3) | bits(w, 47, 3)};
				c2 = '{bits(w, 43, 4), bits(w, 39, 4), bits(w, 35, 4)};
				ord = ((c1[0] << 8) | (c1[1] << 4) | c1[2]) >=
					((c2[0] << 8) | (c2[1] << 4) | c2[2]) ? 1 : 0;
				d = TH_DIST[(bits(w, 34, 1) << 2) | (bits(w, 32, 1) << 1) | ord];
				for (int i = 0; i < 3; i++) begin
					p = (idx < 2) ? x4(c1[i]) : x4(c2[i]);
					c[i] = (idx & 1) ? clamp8(p - d) : clamp8(p + d);
				end
				return;
			end
			if (b2 < 0 || b2 > 31) begin
				c[0] = plane_val(x6(bits(w, 57, 6)),
					x6((bits(w, 34, 5) << 1) | bits(w, 32, 1)), x6(bits(w, 13, 6)), x, y);
				c[1] = plane_val(x7((bits(w, 56, 1) << 6) | bits(w, 49, 6)),
					x7(bits(w, 25, 7)), x7(bits(w, 6, 7)), x, y);
				c[2] = plane_val(x6((bits(w, 48, 1) << 5) | (bits(w, 43, 2) << 3) |
					bits(w, 39, 3)), x6(bits(w, 19, 6)), x6(bits(w, 0, 6)), x, y);
				return;
			end
			b0 = '{x5(r5), x5(g5), x5(b5)};
			b1 = '{x5(r2), x5(g2), x5(b2)};
		end
		sub = bits(w, 32, 1) ? (y >= 2) : (x >= 2);
		tw = sub ? bits(w, 34, 3) : bits(w, 37, 3);
		m = ETC_MOD[tw][idx];
		for (int i = 0; i < 3; i++) c[i] = clamp8((sub ? b1[i] : b0[i]) + m);
	endfunction

	function automatic int decode_alpha(input logic [63:0] w, input int x, input int y);
		return clamp8(bits(w, 56, 8) +
			ALPHA_MOD[bits(w, 48, 4)][bits(w, 45 - 3 * (x * 4 + y), 3)] * bits(w, 52, 4));
	endfunction

	// Expected pixels, one block at a time
	class pixel_scoreboard;
		etc2_pkg::out_word_t pending[$];
		int errors;
		int pixels;

		function void note_block(input etc2_pkg::in_word_t blk, input bit has_alpha);
			etc2_pkg::out_word_t o;
			int c[3];
			for (int k = 0; k < 16; k++) begin
				decode_rgb(blk.color_word, k & 3, k >> 2, c);
				o.red = 8'(c[0]); o.green = 8'(c[1]); o.blue = 8'(c[2]);
				o.alpha = has_alpha ? 8'(decode_alpha(blk.alpha_word, k & 3, k >> 2))
					: 8'd255;
				o.pixel_x = 2'(k & 3); o.pixel_y = 2'(k >> 2);
				o.last_pixel = (k == 15);
				pending.push_back(o);
			end
		endfunction

		function void check_pixel(input etc2_pkg::out_word_t got);
			etc2_pkg::out_word_t e;
			pixels++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel %h", $time, got);
				return;
			end
			e = pending.pop_front();
			if (got.red !== e.red) mismatch("red", e.red, got.red);
			if (got.green !== e.green) mismatch("green", e.green, got.green);
			if (got.blue !== e.blue) mismatch("blue", e.blue, got.blue);
			if (got.alpha !== e.alpha) mismatch("alpha", e.alpha, got.alpha);
			if (got.pixel_x !== e.pixel_x)
				mismatch("pixel_x", 8'(e.pixel_x), 8'(got.pixel_x));
			if (got.pixel_y !== e.pixel_y)
				mismatch("pixel_y", 8'(e.pixel_y), 8'(got.pixel_y));
			if (got.last_pixel !== e.last_pixel)
				mismatch("last_pixel", 8'(e.last_pixel), 8'(got.last_pixel));
		endfunction

		function void mismatch(input string name, input logic [7:0] e, input logic [7:0] a);
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, e, a);
		endfunction
	endclass

	logic clk, arst_n, push, full, empty, pop, cfg_valid, cfg_ready, cfg_data;
	etc2_pkg::in_word_t in_word;
	etc2_pkg::out_word_t out_word;
	pixel_scoreboard sb;
	bit fmt_alpha;
	bit pop_hold;
	bit calm;
	int blocks;

	etc2_rgba_block_decoder_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_word(in_word),
		.empty(empty), .pop(pop), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	// Drain pixels with random stalls; a long hold-off when asked
	initial begin
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) sb.check_pixel(out_word);
			if (pop_hold) begin
				pop <= 0;
				for (int i = 0; i < 200; i++) @(posedge clk);
				pop_hold = 0;
			end
			pop <= calm ? 1'b1 : ($urandom_range(99) >= 12);
		end
	end

	// Offer one block until accepted; push stays high for a following block
	task automatic send_block(input logic [63:0] cw, input logic [63:0] aw);
		while (!calm && $urandom_range(99) < 12) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		in_word <= '{color_word: cw, alpha_word: aw};
		do @(posedge clk); while (full);
		sb.note_block('{color_word: cw, alpha_word: aw}, fmt_alpha);
		blocks++;
	endtask

	task automatic drain();
		push <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_format(input bit v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		fmt_alpha = v;
	endtask

	// Random color word steered toward one mode
	function automatic logic [63:0] rand_color(input int mode);
		logic [63:0] w;
		int r5, g5, b5;
		w = {$urandom, $urandom};
		if (mode == 0) begin
			w[33] = 0;
			return w;
		end
		w[33] = 1;
		r5 = $urandom_range(31); g5 = $urandom_range(31); b5 = $urandom_range(31);
		w[63:59] = 5'(r5); w[55:51] = 5'(g5); w[47:43] = 5'(b5);
		case (mode)
			1: begin
				w[58:56] = (r5 > 27) ? 3'd0 : 3'($urandom_range(3));
				w[50:48] = (g5 > 27) ? 3'd0 : 3'($urandom_range(3));
				w[42:40] = (b5 > 27) ? 3'd0 : 3'($urandom_range(3));
			end
			2: begin
				w[63:59] = 5'd31; w[58:56] = 3'($urandom_range(1, 3));
			end
			3: begin
				w[58:56] = 3'd0; w[55:51] = 5'd31; w[50:48] = 3'($urandom_range(1, 3));
			end
			default: begin
				w[58:56] = 3'd0; w[50:48] = 3'd0; w[47:43] = 5'd0; w[42:40] = 3'd4;
			end
		endcase
		return w;
	endfunction

	initial begin
		sb = new();
		arst_n = 0; push = 0; in_word = '0; cfg_valid = 0; cfg_data = 0;
		fmt_alpha = 0; pop_hold = 0; calm = 0; blocks = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, each mode, EAC multiplier zero, H ordering
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		drain();
		write_format(1);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'hFFFF_FFFF_0000_FFFF, 64'hFF0F_0000_0000_0000);
		send_block(64'h0000_0000_FFFF_0000, 64'h7D0F_FFFF_FFFF_FFFF);
		for (int m = 0; m < 5; m++) send_block(rand_color(m), {$urandom, $urandom});
		send_block(64'hF900_0000_0000_FFFF, 64'h80FD_B6DB_6DB6_DB6D);
		send_block(64'h07F8_0000_0000_FFFF, 64'h0000_1249_2492_4924);
		send_block(64'h07F8_0002_0000_0000, 64'h5582_AAAA_AAAA_AAAA);
		send_block(64'h07FA_0003_FFFF_0000, 64'h01F0_FFFF_0000_FFFF);
		send_block(64'h0006_0402_FFFF_FFFF, 64'hFE1E_0000_0000_0000);
		send_block(64'hFC00_0006_0000_FFFF, 64'h03F3_DB6D_B6DB_6DB6);
		drain();

		// Random phases across both formats
		for (int ph = 0; ph < 4; ph++) begin
			write_format(ph[0]);
			calm = (ph == 2);
			if (ph == 1) pop_hold = 1;
			for (int i = 0; i < 100; i++)
				send_block(rand_color($urandom_range(4)), {$urandom, $urandom});
			drain();
		end
		write_format(0);
		send_block(rand_color(0), 64'h0);
		drain();

		$display("Decoded %0d blocks, %0d pixels, all five color modes, both formats.",
			blocks, sb.pixels);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire
